// ===== hdl/wildcard_name_matcher_defines.svh =====
// ----------------------------------------------------------------------------
// Wildcard name matcher assertion macros
// Clocked assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_NAME_MATCHER_DEFINES_SVH
`define WILDCARD_NAME_MATCHER_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define WNM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never be seen outside reset
`define WNM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== hdl/wnm_pkg.sv =====
// ----------------------------------------------------------------------------
// Wildcard name matcher package
// Shared constants, action codes and transfer types.
// ----------------------------------------------------------------------------
package wnm_pkg;

  // default capacity of the mask store in bytes
  localparam int unsigned MaxMaskDefault = 32;

  // mask bytes with a special meaning
  localparam logic [7:0] STAR_BYTE  = 8'd42;
  localparam logic [7:0] QMARK_BYTE = 8'd63;

  // width of the padded result word
  localparam int unsigned OutDataW = 8;

  // input transaction kinds
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_NAME   = 2'd2,
    ACT_END    = 2'd3
  } action_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic       feed;
    logic       rearm;
    logic [7:0] char_byte;
  } wnm_ctrl_t;

  // one result, matched in the lowest bit
  typedef struct packed {
    logic mask_overflow;
    logic matched;
  } result_t;

endpackage

// ===== hdl/wildcard_name_matcher.sv =====
// ----------------------------------------------------------------------------
// Wildcard name matcher
// Whole-name glob match of streamed names against a loaded '*'/'?' mask.
// ----------------------------------------------------------------------------
// One transaction per clock cycle of every kind (clear, mask append, name
// byte, end of name) while the skid stage is empty; each end of name result
// is registered, in the skid stage if the output waits. The mask lives in a
// row of MAX_MASK cells, one byte and one activity bit each; a name byte steps
// all cells at once, each handing its advance to the next cell. Closure across
// '*' runs is a carry chain of MAX_MASK+1 bits over the whole row, and that
// chain together with the per-cell byte compare sets the clock period. Mask
// bytes beyond MAX_MASK are dropped and flagged until the next clear. A two
// deep output buffer lets the slave side keep going while a result waits.
module wildcard_name_matcher
  import wnm_pkg::*;
#(
  parameter int unsigned MAX_MASK = MaxMaskDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // [7:0] char_byte
  input  logic [1:0]          s_axis_tuser_i,  // [1:0] action
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o   // [0] matched, [1] mask_overflow
);

  localparam int unsigned LenW = $clog2(MAX_MASK + 1);

  logic            in_acc;
  action_e         action;
  wnm_ctrl_t       ctrl;
  logic            append;
  logic            room;
  logic [LenW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;
  logic            raw_last_q, raw_last_d;
  logic [MAX_MASK:0] raw, star, closed, seed, carry_sum, adv_chain;
  logic            hit;
  logic            push;
  result_t         res_in, res_out;
  logic            space;

  // input transaction decode
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign action          = action_e'(s_axis_tuser_i);
  assign ctrl.feed       = in_acc && (action == ACT_NAME);
  assign ctrl.rearm      = in_acc && (action != ACT_NAME);
  assign ctrl.char_byte  = s_axis_tdata_i;
  assign append          = in_acc && (action == ACT_APPEND);
  assign room            = (len_q != LenW'(MAX_MASK));

  // mask length and sticky overflow
  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (in_acc && (action == ACT_CLEAR)) begin
      len_d = '0;
      ovf_d = 1'b0;
    end else if (append) begin
      if (room) begin
        len_d = len_q + LenW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  // activity of the position past the last cell
  always_comb begin
    raw_last_d = raw_last_q;
    if (ctrl.rearm) begin
      raw_last_d = 1'b0;
    end else if (ctrl.feed) begin
      raw_last_d = adv_chain[MAX_MASK];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      ovf_q      <= 1'b0;
      raw_last_q <= 1'b0;
    end else begin
      len_q      <= len_d;
      ovf_q      <= ovf_d;
      raw_last_q <= raw_last_d;
    end
  end

  // row of cells
  assign adv_chain[0] = 1'b0;
  for (genvar i = 0; i < MAX_MASK; i++) begin : g_cell
    wnm_cell #(
      .FIRST_CELL (i == 0)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .wr_en_i  (append && (len_q == LenW'(i))),
      .in_use_i (LenW'(i) < len_q),
      .closed_i (closed[i]),
      .adv_i    (adv_chain[i]),
      .adv_o    (adv_chain[i+1]),
      .star_o   (star[i]),
      .raw_o    (raw[i])
    );
  end
  assign star[MAX_MASK] = 1'b0;
  assign raw[MAX_MASK]  = raw_last_q;

  // closure across star runs as a carry chain
  assign seed      = raw & star;
  assign carry_sum = star + seed;
  assign closed    = raw | (carry_sum ^ star ^ seed);

  // end of name result
  assign hit                  = (len_q == '0) | closed[len_q];
  assign push                 = in_acc && (action == ACT_END);
  assign res_in.matched       = hit;
  assign res_in.mask_overflow = ovf_q;

  wnm_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res_in),
    .take_i  (m_axis_tvalid_o & m_axis_tready_i),
    .space_o (space),
    .valid_o (m_axis_tvalid_o),
    .res_o   (res_out)
  );

  assign s_axis_tready_o = space;
  assign m_axis_tdata_o  = {{(OutDataW - $bits(result_t)){1'b0}}, res_out};

endmodule

// ===== hdl/wnm_cell.sv =====
// ----------------------------------------------------------------------------
// Wildcard name matcher cell
// Holds one mask byte and the pre-closure activity bit of its position.
// ----------------------------------------------------------------------------
module wnm_cell
  import wnm_pkg::*;
#(
  parameter bit FIRST_CELL = 1'b0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  wnm_ctrl_t ctrl_i,
  input  logic      wr_en_i,
  input  logic      in_use_i,
  input  logic      closed_i,
  input  logic      adv_i,
  output logic      adv_o,
  output logic      star_o,
  output logic      raw_o
);

  logic [7:0] mask_byte_q;
  logic       raw_q, raw_d;
  logic       byte_is_star;
  logic       char_fits;
  logic       stay;

  // mask byte, written once per append at this position
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mask_byte_q <= ctrl_i.char_byte;
    end
  end

  // local transition for the incoming name byte
  assign byte_is_star = (mask_byte_q == STAR_BYTE);
  assign char_fits    = (mask_byte_q == QMARK_BYTE) || (mask_byte_q == ctrl_i.char_byte);
  assign star_o       = in_use_i & byte_is_star;
  assign stay         = closed_i & star_o;
  assign adv_o        = closed_i & in_use_i & ~byte_is_star & char_fits;

  // activity bit: rearm, step, or hold
  always_comb begin
    raw_d = raw_q;
    if (ctrl_i.rearm) begin
      raw_d = FIRST_CELL;
    end else if (ctrl_i.feed) begin
      raw_d = stay | adv_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q <= FIRST_CELL;
    end else begin
      raw_q <= raw_d;
    end
  end

  assign raw_o = raw_q;

endmodule

// ===== hdl/wnm_out_buf.sv =====
// ----------------------------------------------------------------------------
// Wildcard name matcher output buffer
// Output register with a skid stage so input keeps flowing under stall.
// ----------------------------------------------------------------------------
module wnm_out_buf
  import wnm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  input  logic    take_i,
  output logic    space_o,
  output logic    valid_o,
  output result_t res_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_res_q, out_res_d;
  result_t skid_res_q, skid_res_d;

  // next state of both stages
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_res_d    = out_res_q;
    skid_res_d   = skid_res_q;
    if (skid_valid_q) begin
      if (take_i) begin
        out_res_d    = skid_res_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !take_i) begin
        skid_res_d   = res_i;
        skid_valid_d = 1'b1;
      end else begin
        out_res_d   = res_i;
        out_valid_d = 1'b1;
      end
    end else if (take_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  assign space_o = ~skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_res_q;

endmodule

// ===== hdl/wnm_checker.sv =====
// ----------------------------------------------------------------------------
// Wildcard name matcher checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "wildcard_name_matcher_defines.svh"

module wnm_checker
  import wnm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic [1:0]          s_axis_tuser_i,  // [1:0] action
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o   // [0] matched, [1] mask_overflow
);

  logic in_acc;
  logic end_acc;

  // transaction decode
  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign end_acc = in_acc && (s_axis_tuser_i == ACT_END);

  // a held result stays offered
  `WNM_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result dropped")
  // end of name into an empty output shows a result next cycle
  `WNM_ASSERT(a_end_result, end_acc && !m_axis_tvalid_o |=> m_axis_tvalid_o, "missing result")
  // a new result only follows an end of name
  `WNM_ASSERT(a_no_spurious, $rose(m_axis_tvalid_o) |-> $past(end_acc), "result without end")
  // back pressure only with a result waiting
  `WNM_ASSERT_NEVER(a_ready_stall, !s_axis_tready_o && !m_axis_tvalid_o, "stall with empty output")
  // padding bits of the result stay zero
  `WNM_ASSERT_NEVER(a_pad_zero, m_axis_tvalid_o && (m_axis_tdata_o[7:2] != 6'd0), "padding set")

endmodule

bind wildcard_name_matcher wnm_checker u_wnm_checker (.*);

// ===== tb/tb_wildcard_name_matcher.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wildcard name matcher testbench
// Streams mask loads, name bytes and end-of-name markers into the matcher,
// predicts every verdict with an independent bit-vector glob automaton and
// checks each returned verdict in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_wildcard_name_matcher;
  import wnm_pkg::*;

  localparam int unsigned MAX_MASK    = MaxMaskDefault;
  localparam int unsigned RAND_ITEMS  = 1500;
  localparam int unsigned IDLE_PCT    = 33;
  localparam int unsigned DRAIN_CYC   = 10;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    action_e    action;
    logic [7:0] char_byte;
  } wnm_item_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stream signals
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [7:0]          s_data  = '0;
  action_e             s_user  = ACT_CLEAR;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;

  wildcard_name_matcher #(
    .MAX_MASK(MAX_MASK)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),   // [7:0] char_byte
    .s_axis_tuser_i (s_user),   // [1:0] action
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)    // [0] matched, [1] mask_overflow
  );

  // pending stimulus and expected verdicts
  wnm_item_t   pending_items[$];
  result_t     expected_verdicts[$];
  int unsigned items_sent    = 0;
  int unsigned verdicts_seen = 0;
  int unsigned match_count   = 0;
  int unsigned ovf_count     = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;

  // no idling on either side for a stretch in the middle of the run
  wire no_idle = (items_sent >= 500) && (items_sent < 800);

  // glob automaton state: stored mask, live prefix positions, dropped bytes
  logic [7:0]        mask_bytes [MAX_MASK];
  int unsigned       mask_len      = 0;
  logic [MAX_MASK:0] live_pos      = 1;
  logic              bytes_dropped = 1'b0;

  // a live '*' also lets the prefix past it match (empty run)
  function automatic void close_across_stars();
    for (int i = 0; i < MAX_MASK; i++)
      if (i < mask_len && live_pos[i] && mask_bytes[i] == STAR_BYTE)
        live_pos[i+1] = 1'b1;
  endfunction

  function automatic void restart_positions();
    live_pos = 1;
    close_across_stars();
  endfunction

  // step the automaton and queue a verdict for each end of name
  function automatic void track_glob_match(action_e act, logic [7:0] c);
    logic [MAX_MASK:0] nxt;
    result_t           verdict;
    nxt = '0;
    case (act)
      ACT_CLEAR: begin
        mask_len      = 0;
        bytes_dropped = 1'b0;
        restart_positions();
      end
      ACT_APPEND: begin
        if (mask_len < MAX_MASK) begin
          mask_bytes[mask_len] = c;
          mask_len++;
        end else begin
          bytes_dropped = 1'b1;
        end
        restart_positions();
      end
      ACT_NAME: begin
        for (int i = 0; i < MAX_MASK; i++) begin
          if (i < mask_len && live_pos[i]) begin
            if (mask_bytes[i] == STAR_BYTE)
              nxt[i] = 1'b1;
            else if (mask_bytes[i] == QMARK_BYTE || mask_bytes[i] == c)
              nxt[i+1] = 1'b1;
          end
        end
        live_pos = nxt;
        close_across_stars();
      end
      default: begin
        verdict.matched       = (mask_len == 0) ? 1'b1 : live_pos[mask_len];
        verdict.mask_overflow = bytes_dropped;
        expected_verdicts.push_back(verdict);
        restart_positions();
      end
    endcase
  endfunction

  // slave side driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      s_user  <= ACT_CLEAR;
    end else begin
      if (s_valid && s_ready) begin
        track_glob_match(s_user, s_data);
        items_sent++;
      end
      if (!s_valid || s_ready) begin
        if (pending_items.size() > 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          s_valid <= 1'b1;
          s_data  <= pending_items[0].char_byte;
          s_user  <= pending_items[0].action;
          void'(pending_items.pop_front());
        end else begin
          s_valid <= 1'b0;
          s_data  <= 8'($urandom);
          s_user  <= action_e'($urandom_range(0, 3));
        end
      end
    end
  end

  // master side monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        got = result_t'(m_data[1:0]);
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict transaction, actual %b", $time, m_data);
          error_count++;
        end else begin
          want = expected_verdicts.pop_front();
          verdicts_seen++;
          if (got.matched) match_count++;
          if (got.mask_overflow) ovf_count++;
          if (got.matched !== want.matched) begin
            $display("%0t: matched mismatch, expected %b actual %b",
                     $time, want.matched, got.matched);
            error_count++;
          end
          if (got.mask_overflow !== want.mask_overflow) begin
            $display("%0t: mask_overflow mismatch, expected %b actual %b",
                     $time, want.mask_overflow, got.mask_overflow);
            error_count++;
          end
        end
      end
      m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items pending and %0d verdicts outstanding",
               $time, pending_items.size(), expected_verdicts.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_item(action_e act, logic [7:0] c);
    wnm_item_t it;
    it.action    = act;
    it.char_byte = c;
    pending_items.push_back(it);
  endtask

  // mask bytes lean on wildcards and a small alphabet
  function automatic logic [7:0] pick_mask_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return STAR_BYTE;
    if (r < 35) return QMARK_BYTE;
    if (r < 75) return 8'("a" + $urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  // name bytes: small alphabet, literal wildcard bytes, any byte
  function automatic logic [7:0] pick_name_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'("a" + $urandom_range(0, 2));
    if (r < 60) return (r < 55) ? STAR_BYTE : QMARK_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  // stimulus and end of run
  initial begin
    logic [7:0]  gen_mask[$];
    logic [7:0]  name_q[$];
    logic [7:0]  c;
    int unsigned r;
    int unsigned mlen;
    int unsigned stored;
    int unsigned target;

    // directed: empty mask, star only, single '?', literal with star,
    // append in the middle of a name, extreme byte values
    add_item(ACT_END, 8'h00);
    add_item(ACT_NAME, 8'h00);
    add_item(ACT_NAME, 8'hFF);
    add_item(ACT_END, 8'hFF);
    add_item(ACT_APPEND, STAR_BYTE);
    add_item(ACT_END, 8'h00);
    add_item(ACT_NAME, "x");
    add_item(ACT_END, 8'h00);
    add_item(ACT_CLEAR, 8'hFF);
    add_item(ACT_APPEND, QMARK_BYTE);
    add_item(ACT_END, 8'h00);
    add_item(ACT_NAME, 8'hFF);
    add_item(ACT_END, 8'h00);
    add_item(ACT_CLEAR, 8'h00);
    add_item(ACT_APPEND, "a");
    add_item(ACT_APPEND, STAR_BYTE);
    add_item(ACT_APPEND, "b");
    add_item(ACT_NAME, "a");
    add_item(ACT_APPEND, "c");
    add_item(ACT_NAME, "a");
    add_item(ACT_NAME, "b");
    add_item(ACT_NAME, "c");
    add_item(ACT_END, 8'h00);
    add_item(ACT_END, 8'hFF);
    gen_mask = '{"a", STAR_BYTE, "b", "c"};

    // random: mostly a mask load followed by names built from it
    target = pending_items.size() + RAND_ITEMS;
    while (pending_items.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // noise transactions
        repeat ($urandom_range(1, 4))
          add_item(action_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        if (r < 92) begin
          add_item(ACT_CLEAR, 8'($urandom));
          gen_mask.delete();
        end
        r = $urandom_range(0, 99);
        if (r < 77)      mlen = $urandom_range(0, 6);
        else if (r < 92) mlen = $urandom_range(7, 20);
        else             mlen = $urandom_range(28, 40);
        repeat (mlen) begin
          c = pick_mask_char();
          add_item(ACT_APPEND, c);
          gen_mask.push_back(c);
        end
        repeat ($urandom_range(1, 4)) begin
          name_q.delete();
          stored = (gen_mask.size() < MAX_MASK) ? gen_mask.size() : MAX_MASK;
          if ($urandom_range(0, 99) < 25) begin
            repeat ($urandom_range(0, 6)) name_q.push_back(pick_name_char());
          end else begin
            for (int i = 0; i < stored; i++) begin
              if (gen_mask[i] == STAR_BYTE)
                repeat ($urandom_range(0, 3)) name_q.push_back(pick_name_char());
              else if (gen_mask[i] == QMARK_BYTE)
                name_q.push_back(pick_name_char());
              else
                name_q.push_back(gen_mask[i]);
            end
            // spoil one byte now and then
            if (name_q.size() > 0 && $urandom_range(0, 99) < 20)
              name_q[$urandom_range(0, name_q.size() - 1)] = pick_name_char();
          end
          foreach (name_q[i]) begin
            add_item(ACT_NAME, name_q[i]);
            // broken sequence: mask grows in the middle of a name
            if ($urandom_range(0, 99) < 4) begin
              c = pick_mask_char();
              add_item(ACT_APPEND, c);
              gen_mask.push_back(c);
            end
          end
          add_item(ACT_END, 8'($urandom));
        end
      end
    end

    // reset
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait for every transaction to be taken, then for every verdict
    while (pending_items.size() != 0 || s_valid) @(negedge clk_i);
    while (expected_verdicts.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);

    $display("covered %0d transactions and %0d verdicts (%0d matches, %0d with mask overflow)",
             items_sent, verdicts_seen, match_count, ovf_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
